[design/ptp_pkg.sv]
// ----------------------------------------------------------------------------
// ptp_pkg
// Types, codes and helpers shared by the perceptron train/predict unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ptp_pkg;

  localparam int N_FEAT  = 4;               // features per sample, one lane each
  localparam int FEAT_W  = 16;              // signed Q8.8 feature
  localparam int WGT_W   = 32;              // signed Q16.16 weight
  localparam int LR_W    = 16;              // unsigned Q0.16 learning rate
  localparam int PROD_W  = WGT_W + FEAT_W;  // exact weight*feature, Q.24
  localparam int LRX_W   = LR_W + 1 + FEAT_W; // lr*feature, Q8.24
  localparam int STEP_W  = LRX_W - 8;       // lr*feature floored to Q16.16
  localparam int ACC_W   = WGT_W + 2;       // weight plus or minus a step

  // features, label, zero pad to whole bytes
  localparam int IN_DATA_W = ((N_FEAT * FEAT_W + 1 + 7) / 8) * 8;

  localparam logic [LR_W-1:0] LR_RESET = 16'd6554;

  localparam logic [31:0] WGT_MAX = 32'h7fff_ffff;
  localparam logic [31:0] WGT_MIN = 32'h8000_0000;

  typedef enum logic [1:0] {
    ACT_PREDICT = 2'd0,
    ACT_TRAIN   = 2'd1,
    ACT_CLEAR   = 2'd2,
    ACT_SPARE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_MUL  = 2'd1,
    ST_SUM  = 2'd2,
    ST_UPD  = 2'd3
  } state_t;

  localparam logic [1:0] ERR_ZERO = 2'b00;
  localparam logic [1:0] ERR_POS  = 2'b01;
  localparam logic [1:0] ERR_NEG  = 2'b11;

  localparam logic REG_LR = 1'b0;  // register index of the learning rate

  typedef logic signed [PROD_W-1:0] prod_t;

  typedef struct packed {
    logic mul_en;  // capture product and step
    logic upd_en;  // apply the step to the weight
    logic clr;     // zero the weight
    logic neg;     // subtract the step instead of adding it
  } lane_ctl_t;

  typedef struct packed {
    logic             sat;
    logic [WGT_W-1:0] value;
  } wgt_upd_t;

  // Add or subtract a step and clip to the signed 32-bit range.
  function automatic wgt_upd_t upd_weight(input logic [WGT_W-1:0] w,
                                          input logic [ACC_W-1:0] step,
                                          input logic             neg);
    logic [ACC_W-1:0] acc;
    wgt_upd_t         res;
    acc = {{2{w[WGT_W-1]}}, w} + (neg ? (~step + 1'b1) : step);
    res.sat = (acc[ACC_W-1:WGT_W-1] != {3{acc[WGT_W-1]}});
    if (res.sat) begin
      res.value = acc[ACC_W-1] ? WGT_MIN : WGT_MAX;
    end else begin
      res.value = acc[WGT_W-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[design/perceptron_train_predict_unit.sv]
// ----------------------------------------------------------------------------
// perceptron_train_predict_unit
// Perceptron with bias and N_FEAT weights: predict, train and clear.
// ----------------------------------------------------------------------------
// Flow: an item is accepted, then passes through the multiply, sum and update
//   states in turn; no new item is accepted until its result is registered, and
//   the update stage waits while a previous result is still held at the output.
// Reset: synchronous, active low; weights and bias clear to zero, the
//   learning rate returns to 6554 (about 0.1).
// ----------------------------------------------------------------------------
`default_nettype none

module perceptron_train_predict_unit
  import ptp_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // input stream
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  // tdata: feature_0 .. feature_(N-1) (16 bits each), label, zero pad
  input  wire logic [IN_DATA_W-1:0] in_tdata,
  // tuser: action
  input  wire logic [1:0]           in_tuser,
  // result stream
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  // tdata: predicted, error[1:0], saturated, zero pad
  output logic [7:0]                out_tdata,
  // configuration port
  input  wire logic                 cfg_psel,
  input  wire logic                 cfg_penable,
  input  wire logic                 cfg_pwrite,
  input  wire logic [2:0]           cfg_paddr,
  input  wire logic [31:0]          cfg_pwdata,
  output logic [31:0]               cfg_prdata,
  output logic                      cfg_pready
);

  state_t                  state_r, state_nxt;
  action_t                 act_r, act_nxt;
  logic                    label_r, label_nxt;
  logic signed [FEAT_W-1:0] feat_r   [N_FEAT];
  logic signed [FEAT_W-1:0] feat_nxt [N_FEAT];
  logic [LR_W-1:0]         lr_r, lr_nxt;
  logic [WGT_W-1:0]        bias_r, bias_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [7:0]              out_data_r, out_data_nxt;

  lane_ctl_t               lane_ctl;
  prod_t                   prods [N_FEAT];
  logic [N_FEAT-1:0]       lane_sat;
  logic                    pred;
  logic                    accept;
  logic                    room;
  logic                    is_train;
  logic                    is_clear;
  logic                    do_step;
  logic [1:0]              err;
  wgt_upd_t                bias_upd;
  logic                    cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == REG_LR) ? {{(32-LR_W){1'b0}}, lr_r} : 32'h0;

  assign in_tready  = (state_r == ST_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign room       = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign is_train = (act_r == ACT_TRAIN);
  assign is_clear = (act_r == ACT_CLEAR);
  assign do_step  = is_train && (label_r != pred);

  always_comb begin
    if (!is_train || (label_r == pred)) begin
      err = ERR_ZERO;
    end else if (label_r) begin
      err = ERR_POS;
    end else begin
      err = ERR_NEG;
    end
  end

  // lanes
  always_comb begin
    lane_ctl.mul_en = (state_r == ST_MUL);
    lane_ctl.upd_en = (state_r == ST_UPD) && room && do_step;
    lane_ctl.clr    = (state_r == ST_UPD) && room && is_clear;
    lane_ctl.neg    = pred;
  end

  for (genvar g = 0; g < N_FEAT; g++) begin : g_lane
    ptp_lane u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (lane_ctl),
      .feature (feat_r[g]),
      .lr      (lr_r),
      .prod    (prods[g]),
      .sat     (lane_sat[g])
    );
  end

  ptp_merge u_merge (
    .clk   (clk),
    .en    (state_r == ST_SUM),
    .bias  (bias_r),
    .prods (prods),
    .pred  (pred)
  );

  // control and bias
  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    label_nxt     = label_r;
    feat_nxt      = feat_r;
    lr_nxt        = lr_r;
    bias_nxt      = bias_r;
    out_valid_nxt = out_tready ? 1'b0 : out_valid_r;
    out_data_nxt  = out_data_r;
    bias_upd      = upd_weight(bias_r, {{(ACC_W-LR_W){1'b0}}, lr_r}, pred);

    if (cfg_wr && (cfg_paddr[2] == REG_LR)) begin
      lr_nxt = cfg_pwdata[LR_W-1:0];
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          act_nxt   = action_t'(in_tuser);
          label_nxt = in_tdata[N_FEAT*FEAT_W];
          for (int i = 0; i < N_FEAT; i++) begin
            feat_nxt[i] = in_tdata[i*FEAT_W +: FEAT_W];
          end
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        // hold until the output register is free
        if (room) begin
          if (is_clear) begin
            bias_nxt     = '0;
            out_data_nxt = 8'h00;
          end else begin
            if (do_step) begin
              bias_nxt = bias_upd.value;
            end
            out_data_nxt = {4'h0,
                            do_step && (bias_upd.sat || (|lane_sat)),
                            err,
                            pred};
          end
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      lr_r        <= LR_RESET;
      bias_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lr_r        <= lr_nxt;
      bias_r      <= bias_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    label_r    <= label_nxt;
    feat_r     <= feat_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

[design/ptp_lane.sv]
// ----------------------------------------------------------------------------
// ptp_lane
// One feature lane: holds its weight, forms weight*feature for the
// prediction and the floored lr*feature step, then applies the update or clears the weight.
// ----------------------------------------------------------------------------
`default_nettype none

module ptp_lane
  import ptp_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire lane_ctl_t                ctl,
  input  wire logic signed [FEAT_W-1:0] feature,
  input  wire logic        [LR_W-1:0]   lr,
  output prod_t                         prod,
  output logic                          sat
);

  logic        [WGT_W-1:0]  weight_r, weight_nxt;
  prod_t                    prod_r, prod_nxt;
  logic signed [STEP_W-1:0] step_r, step_nxt;
  logic signed [LRX_W-1:0]  lr_x;
  wgt_upd_t                 upd;

  always_comb begin
    lr_x     = $signed({1'b0, lr}) * feature;
    prod_nxt = ctl.mul_en ? prod_t'($signed(weight_r) * feature) : prod_r;
    // drop the low byte: floor to Q16.16
    step_nxt = ctl.mul_en ? lr_x[LRX_W-1:8] : step_r;

    upd = upd_weight(weight_r, ACC_W'(step_r), ctl.neg);
    sat = 1'b0;
    weight_nxt = weight_r;
    if (ctl.clr) begin
      weight_nxt = '0;
    end else if (ctl.upd_en) begin
      weight_nxt = upd.value;
      sat        = upd.sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r <= '0;
    end else begin
      weight_r <= weight_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    step_r <= step_nxt;
  end

  assign prod = prod_r;

endmodule

`default_nettype wire

[design/ptp_merge.sv]
// ----------------------------------------------------------------------------
// ptp_merge
// Sums the bias and the lane products and registers the class decision.
// ----------------------------------------------------------------------------
`default_nettype none

module ptp_merge
  import ptp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [WGT_W-1:0] bias,
  input  wire prod_t            prods [N_FEAT],
  output logic                  pred
);

  localparam int SUM_W = PROD_W + $clog2(N_FEAT + 1) + 1;

  logic signed [SUM_W-1:0] sum;
  logic                    pred_r, pred_nxt;

  always_comb begin
    // bias is Q16.16, products are Q.24
    sum = $signed({{(SUM_W-WGT_W-8){bias[WGT_W-1]}}, bias, 8'h00});
    for (int i = 0; i < N_FEAT; i++) begin
      sum = sum + SUM_W'(prods[i]);
    end
    pred_nxt = en ? (!sum[SUM_W-1] && (sum != '0)) : pred_r;
  end

  always_ff @(posedge clk) begin
    pred_r <= pred_nxt;
  end

  assign pred = pred_r;

endmodule

`default_nettype wire

[dv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for perceptron_train_predict_unit. Items go in over the
// input stream and results are checked one for one against a cycle-free model
// of the weights and the learning rate kept alongside the block.
// ----------------------------------------------------------------------------

module tb
  import ptp_pkg::*;
();

  typedef struct packed {
    logic       sat;
    logic [1:0] err;
    logic       pred;
  } outcome_t;

  localparam logic [2:0] LR_ADDR     = {REG_LR, 2'b00};
  localparam longint     SAT_HI      = 64'sd2147483647;
  localparam longint     SAT_LO      = -64'sd2147483648;
  localparam int         MAX_REPORTS = 60;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  // tdata: feature_0 .. feature_3 (16 bits each), label, zero pad
  logic [71:0] in_tdata    = '0;
  // tuser: action
  logic [1:0]  in_tuser    = ACT_PREDICT;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  // tdata: predicted, error[1:0], saturated, zero pad
  logic [7:0]  out_tdata;
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [2:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // shadow of the block's state: bias in entry 0, then one weight per feature
  logic signed [WGT_W-1:0] model_wgt [5] = '{default: '0};
  logic [LR_W-1:0]         model_lr      = LR_RESET;
  outcome_t                expected_outcomes [$];

  int          sender_idle_pct   = 0;
  int          receiver_idle_pct = 0;
  int unsigned fail_cnt     = 0;
  int unsigned reports      = 0;
  int unsigned items_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned action_cnt [4] = '{default: 0};
  int unsigned err_pos_cnt  = 0;
  int unsigned err_neg_cnt  = 0;
  int unsigned sat_cnt      = 0;
  int unsigned lr_writes    = 0;

  perceptron_train_predict_unit i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
  end

  function automatic void note_mismatch(input string what, input int want, input int got);
    fail_cnt++;
    if (reports < MAX_REPORTS) begin
      reports++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
    end
  endfunction

  // One item through the perceptron: a clear item zeroes the weights; otherwise classify
  // on the current weights, then apply the learning rule on a train item.
  function automatic outcome_t classify_and_learn(input action_t act, input logic [63:0] feat,
                                                  input logic lbl);
    outcome_t res;
    longint   acc;
    longint   stepv;
    longint   nw;
    int       err;
    int       i;
    res = '0;
    err = 0;
    if (act == ACT_CLEAR) begin
      for (i = 0; i < 5; i++) model_wgt[i] = '0;
      return res;
    end
    acc = longint'(model_wgt[0]) * 256;
    for (i = 0; i < 4; i++) begin
      acc += longint'(model_wgt[i+1]) * longint'($signed(feat[16*i +: 16]));
    end
    res.pred = (acc > 0);
    if (act == ACT_TRAIN) begin
      err = int'(lbl) - int'(res.pred);
      for (i = 0; i <= 4 && err != 0; i++) begin
        if (i == 0) begin
          stepv = longint'(model_lr);
        end else begin
          // Q8.24 product floored to Q16.16
          stepv = (longint'(model_lr) * longint'($signed(feat[16*(i-1) +: 16]))) >>> 8;
        end
        nw = longint'(model_wgt[i]) + longint'(err) * stepv;
        if (nw > SAT_HI) begin
          nw      = SAT_HI;
          res.sat = 1'b1;
        end else if (nw < SAT_LO) begin
          nw      = SAT_LO;
          res.sat = 1'b1;
        end
        model_wgt[i] = nw[31:0];
      end
    end
    res.err = (err > 0) ? ERR_POS : (err < 0) ? ERR_NEG : ERR_ZERO;
    return res;
  endfunction

  task automatic send_sample(input action_t act, input logic [63:0] feat, input logic lbl);
    outcome_t res;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {7'b0, lbl, feat};
    do @(posedge clk); while (!in_tready);
    res = classify_and_learn(act, feat, lbl);
    expected_outcomes.push_back(res);
    items_sent++;
    action_cnt[act]++;
    if (res.err == ERR_POS) err_pos_cnt++;
    if (res.err == ERR_NEG) err_neg_cnt++;
    if (res.sat) sat_cnt++;
  endtask

  // Drop valid, let every outstanding result come back, then let the
  // pipeline settle.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (expected_outcomes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic apb_transfer(input logic wr, input logic [LR_W-1:0] wdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= LR_ADDR;
    cfg_pwdata  <= {16'h0000, wdata};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (wr) begin
      model_lr = wdata;
    end else if (cfg_prdata !== {16'h0000, model_lr}) begin
      note_mismatch("rate readback", int'(model_lr), int'(cfg_prdata));
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_learning_rate(input logic [LR_W-1:0] lr);
    drain_results();
    apb_transfer(1'b1, lr);
    apb_transfer(1'b0, '0);
    lr_writes++;
  endtask

  function automatic logic [15:0] rand_feature();
    logic [15:0] f;
    case ($urandom_range(0, 3))
      0: f = 16'($urandom);
      1: f = 16'($urandom_range(0, 1023) - 512);
      2: begin
        case ($urandom_range(0, 4))
          0: f = 16'h8000;
          1: f = 16'h7fff;
          2: f = 16'hffff;
          3: f = 16'h0001;
          default: f = 16'h0000;
        endcase
      end
      default: f = 16'($urandom_range(0, 16383) - 8192);
    endcase
    return f;
  endfunction

  // A small data set, labeled by a hidden hyperplane or at random, trained
  // for a few epochs and then scored.
  task automatic train_and_score_set();
    logic [63:0] set_feat [8];
    logic        set_lbl  [8];
    int          hyper    [5];
    int          n;
    int          epochs;
    int          e;
    int          k;
    int          i;
    longint      dot;
    logic        noisy;
    n      = $urandom_range(2, 8);
    epochs = $urandom_range(1, 4);
    noisy  = ($urandom_range(0, 3) == 0);
    for (i = 0; i < 5; i++) hyper[i] = int'($urandom_range(0, 200)) - 100;
    for (k = 0; k < n; k++) begin
      dot = longint'(hyper[0]) * 256;
      for (i = 0; i < 4; i++) begin
        set_feat[k][16*i +: 16] = rand_feature();
        dot += longint'(hyper[i+1]) * longint'($signed(set_feat[k][16*i +: 16]));
      end
      set_lbl[k] = noisy ? 1'($urandom_range(0, 1)) : (dot > 0);
    end
    // mostly start from zero weights; otherwise keep what earlier sets built up
    if ($urandom_range(0, 3) != 0) begin
      send_sample(ACT_CLEAR, {$urandom, $urandom}, 1'($urandom_range(0, 1)));
    end
    for (e = 0; e < epochs; e++) begin
      for (k = 0; k < n; k++) send_sample(ACT_TRAIN, set_feat[k], set_lbl[k]);
    end
    for (k = 0; k < n; k++) begin
      send_sample(ACT_PREDICT, set_feat[k], 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic send_noise_burst();
    int k;
    int count;
    count = $urandom_range(1, 5);
    for (k = 0; k < count; k++) begin
      send_sample(action_t'(2'($urandom_range(0, 3))), {$urandom, $urandom},
                  1'($urandom_range(0, 1)));
    end
  endtask

  task automatic test_after_reset();
    apb_transfer(1'b0, '0);
    send_sample(ACT_PREDICT, '0, 1'b0);
    send_sample(ACT_PREDICT, {16'h7fff, 16'h8000, 16'h7fff, 16'h8000}, 1'b1);
  endtask

  task automatic test_each_action();
    logic [63:0] mixed;
    // feature_3 .. feature_0
    mixed = {16'hffff, 16'h0001, 16'h8000, 16'h7fff};
    send_sample(ACT_TRAIN, mixed, 1'b1);
    send_sample(ACT_PREDICT, mixed, 1'b0);
    send_sample(ACT_SPARE, mixed, 1'b0);
    send_sample(ACT_TRAIN, mixed, 1'b0);
    send_sample(ACT_TRAIN, {4{16'h8000}}, 1'b1);
    send_sample(ACT_CLEAR, {4{16'hffff}}, 1'b1);
    send_sample(ACT_PREDICT, mixed, 1'b1);
    send_sample(ACT_TRAIN, '0, 1'b0);
    // bias-only update, then a prediction that rests on the bias alone
    send_sample(ACT_TRAIN, '0, 1'b1);
    send_sample(ACT_PREDICT, '0, 1'b0);
    send_sample(ACT_TRAIN, {4{16'h8000}}, 1'b0);
    send_sample(ACT_CLEAR, {4{16'h7fff}}, 1'b0);
  endtask

  task automatic test_learning_rate_sweep();
    logic [LR_W-1:0] rates [5];
    logic [63:0]     probe;
    int              k;
    rates    = '{16'h0000, 16'hffff, 16'h0001, 16'h0100, 16'h0000};
    rates[4] = 16'($urandom);
    probe    = {16'h8000, 16'h0001, 16'hffff, 16'h7fff};
    for (k = 0; k < 5; k++) begin
      set_learning_rate(rates[k]);
      send_sample(ACT_TRAIN, probe, (k % 2) == 0);
      send_sample(ACT_PREDICT, probe, 1'b0);
    end
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct, input int quota);
    int unsigned start;
    sender_idle_pct   = send_pct;
    receiver_idle_pct = recv_pct;
    set_learning_rate(16'($urandom));
    start = items_sent;
    while (items_sent - start < quota) begin
      if ($urandom_range(0, 9) < 7) begin
        train_and_score_set();
      end else begin
        send_noise_burst();
      end
    end
  endtask

  always @(posedge clk) begin
    outcome_t want;
    outcome_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = outcome_t'(out_tdata[3:0]);
      results_seen++;
      if (expected_outcomes.size() == 0) begin
        fail_cnt++;
        if (reports < MAX_REPORTS) begin
          reports++;
          $display("%0t: result %h arrived with no item outstanding", $time, out_tdata);
        end
      end else begin
        want = expected_outcomes.pop_front();
        if (got.pred !== want.pred) note_mismatch("predicted", want.pred, got.pred);
        if (got.err !== want.err) begin
          note_mismatch("error", $signed(want.err), $signed(got.err));
        end
        if (got.sat !== want.sat) note_mismatch("saturated", want.sat, got.sat);
        if (out_tdata[7:4] !== 4'b0000) note_mismatch("tdata pad", 0, out_tdata[7:4]);
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_after_reset();
    test_each_action();
    test_learning_rate_sweep();
    test_random_traffic(29, 88, 165);
    test_random_traffic(88, 29, 165);
    test_random_traffic(0, 0, 165);
    drain_results();
    $display("%0d items (%0d predict, %0d train, %0d clear, %0d spare code), %0d results checked",
             items_sent, action_cnt[ACT_PREDICT], action_cnt[ACT_TRAIN],
             action_cnt[ACT_CLEAR], action_cnt[ACT_SPARE], results_seen);
    $display("train errors +1: %0d, -1: %0d; clipped updates: %0d; rate set %0d times; %0d bad",
             err_pos_cnt, err_neg_cnt, sat_cnt, lr_writes, fail_cnt);
    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout: %0d results still outstanding", expected_outcomes.size());
    $display("Verification failed");
    $finish;
  end

endmodule
